// ----- hw/rtl/mm3_pkg.sv -----
// Shared constants, types and helpers for the 3x3 fixed-point matrix multiplier.
`default_nettype none

package mm3_pkg;

    localparam int MAT_DIM       = 3;
    localparam int ELEM_COUNT    = MAT_DIM * MAT_DIM;
    localparam int ADDR_W        = $clog2(ELEM_COUNT);
    localparam int IDX_W         = 2;
    localparam int DEF_ELEM_W    = 32;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAT_DIM - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT  = 3'b100
    } t_state;

    // Row-major address: row * 3 + col.
    function automatic logic [ADDR_W-1:0] f_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
        logic [ADDR_W-1:0] v_row;
        logic [ADDR_W-1:0] v_col;
        v_row  = ADDR_W'(row);
        v_col  = ADDR_W'(col);
        f_addr = (v_row << 1) + v_row + v_col;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mm3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mm3_ram
    import mm3_pkg::*;
#(
    parameter  int WIDTH = DEF_ELEM_W,
    parameter  int DEPTH = ELEM_COUNT,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AddrW-1:0] i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/matrix_multiply_3x3.sv -----
// Top level: 3x3 signed fixed-point matrix multiplier with memory-held operands.
`default_nettype none

// Each input transfer with row and column below 3 loads one element of the
// left or right matrix into its RAM; both matrices read as zero after reset
// (per-entry valid bits, no clear pass). A transfer with the compute flag set
// stores its element, then the block streams the nine product elements in
// row-major order, the ninth with tlast. Each product element takes three
// operand reads from the RAMs through one shared multiplier, then the
// multiply, accumulate and shift/saturate stages drain; the input is held off
// for the whole compute sequence. Sums are exact, shifted right
// arithmetically by FRAC_BITS and clipped to ELEMENT_WIDTH bits with tuser
// set on clipping. Back-pressure on the output stalls the sequencer.
module matrix_multiply_3x3
    import mm3_pkg::*;
#(
    parameter  int ELEMENT_WIDTH = DEF_ELEM_W,
    parameter  int FRAC_BITS     = DEF_FRAC_BITS,
    localparam int DataW         = ((ELEMENT_WIDTH + 2 * IDX_W + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // row_index, col_index, element_value, zero pad
    input  wire logic [DataW-1:0] s_axis_tdata,
    // which_matrix, compute_after
    input  wire logic [1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // out_row, out_col, product_value, zero pad
    output logic      [DataW-1:0] m_axis_tdata,
    // saturated
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int ProdW = 2 * ELEMENT_WIDTH;
    localparam int AccW  = ProdW + 2;
    localparam int ValLo = 2 * IDX_W;
    localparam int ValHi = ValLo + ELEMENT_WIDTH - 1;
    localparam logic [ELEMENT_WIDTH-1:0] MaxVal = {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
    localparam logic [ELEMENT_WIDTH-1:0] MinVal = {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

    // input side
    logic                     w_in_xfer;
    logic [IDX_W-1:0]         w_in_row;
    logic [IDX_W-1:0]         w_in_col;
    logic [ELEMENT_WIDTH-1:0] w_in_val;
    logic                     w_in_ok;
    logic [ADDR_W-1:0]        w_waddr;
    logic                     w_we_l;
    logic                     w_we_r;

    // sequencer
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic             w_issue;
    logic             w_load;
    logic [ADDR_W-1:0] w_laddr;
    logic [ADDR_W-1:0] w_raddr;

    logic r_lvalid [ELEM_COUNT];
    logic r_rvalid [ELEM_COUNT];

    // pipeline
    logic                     r_rd_vld, r_rd_first, r_rd_last, r_lok, r_rok;
    logic [ELEMENT_WIDTH-1:0] w_ldata, w_rdata;
    logic signed [ELEMENT_WIDTH-1:0] w_lop, w_rop;
    logic signed [ProdW-1:0]  w_prod;
    logic signed [ProdW-1:0]  r_prod;
    logic                     r_prod_vld, r_prod_first, r_prod_last;
    logic signed [AccW-1:0]   r_acc;
    logic                     r_acc_done;
    logic signed [AccW-1:0]   w_shift;
    logic [AccW-ELEMENT_WIDTH:0] w_upper;
    logic                     w_fits;
    logic [ELEMENT_WIDTH-1:0] w_res;

    // output register
    logic                     r_out_vld;
    logic [IDX_W-1:0]         r_out_row, r_out_col;
    logic [ELEMENT_WIDTH-1:0] r_out_val;
    logic                     r_out_sat, r_out_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_in_row      = s_axis_tdata[IDX_W-1:0];
    assign w_in_col      = s_axis_tdata[ValLo-1:IDX_W];
    assign w_in_val      = s_axis_tdata[ValHi:ValLo];
    assign w_in_ok       = (w_in_row != 2'd3) && (w_in_col != 2'd3);
    assign w_waddr       = f_addr(w_in_row, w_in_col);
    assign w_we_l        = w_in_xfer && w_in_ok && !s_axis_tuser[0];
    assign w_we_r        = w_in_xfer && w_in_ok && s_axis_tuser[0];

    assign w_issue = (r_state == ST_ISSUE);
    assign w_laddr = f_addr(r_i, r_k);
    assign w_raddr = f_addr(r_k, r_j);
    assign w_load  = (r_state == ST_WAIT) && r_acc_done && (!r_out_vld || m_axis_tready);

    mm3_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (ELEM_COUNT)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_l),
        .i_waddr (w_waddr),
        .i_wdata (w_in_val),
        .i_raddr (w_laddr),
        .o_rdata (w_ldata)
    );

    mm3_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (ELEM_COUNT)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_r),
        .i_waddr (w_waddr),
        .i_wdata (w_in_val),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && s_axis_tuser[1]) begin
                    n_state = ST_ISSUE;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            ST_ISSUE: begin
                if (r_k == IDX_LAST) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_WAIT: begin
                if (w_load) begin
                    if (r_i == IDX_LAST && r_j == IDX_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_ISSUE;
                        if (r_j == IDX_LAST) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ELEM_COUNT; e++) begin
                r_lvalid[e] <= 1'b0;
                r_rvalid[e] <= 1'b0;
            end
        end else begin
            if (w_we_l) begin
                r_lvalid[w_waddr] <= 1'b1;
            end
            if (w_we_r) begin
                r_rvalid[w_waddr] <= 1'b1;
            end
        end
    end

    // read stage: track request alongside the RAM read latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
        end
        r_rd_first <= (r_k == '0);
        r_rd_last  <= (r_k == IDX_LAST);
        r_lok      <= r_lvalid[w_laddr];
        r_rok      <= r_rvalid[w_raddr];
    end

    assign w_lop  = r_lok ? signed'(w_ldata) : '0;
    assign w_rop  = r_rok ? signed'(w_rdata) : '0;
    assign w_prod = w_lop * w_rop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= r_rd_vld;
        end
        r_prod       <= w_prod;
        r_prod_first <= r_rd_first;
        r_prod_last  <= r_rd_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_done <= 1'b0;
        end else if (r_prod_vld && r_prod_last) begin
            r_acc_done <= 1'b1;
        end else if (w_load) begin
            r_acc_done <= 1'b0;
        end
        if (r_prod_vld) begin
            r_acc <= (r_prod_first ? AccW'(0) : r_acc) + AccW'(r_prod);
        end
    end

    assign w_shift = r_acc >>> FRAC_BITS;
    assign w_upper = w_shift[AccW-1:ELEMENT_WIDTH-1];
    assign w_fits  = (&w_upper) || !(|w_upper);
    assign w_res   = w_fits ? w_shift[ELEMENT_WIDTH-1:0] :
                     (r_acc[AccW-1] ? MinVal : MaxVal);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if (w_load) begin
            r_out_row  <= r_i;
            r_out_col  <= r_j;
            r_out_val  <= w_res;
            r_out_sat  <= !w_fits;
            r_out_last <= (r_i == IDX_LAST) && (r_j == IDX_LAST);
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = DataW'({r_out_val, r_out_col, r_out_row});
    assign m_axis_tuser  = r_out_sat;
    assign m_axis_tlast  = r_out_last;

    a_last_is_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[IDX_W-1:0] == IDX_LAST && m_axis_tdata[ValLo-1:IDX_W] == IDX_LAST)
        else $error("tlast on a product element other than the last corner");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[ValHi:ValLo] == MaxVal || m_axis_tdata[ValHi:ValLo] == MinVal)
        else $error("saturation flag set on a non-limit value");

    a_compute_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && s_axis_tuser[1] |=> r_state == ST_ISSUE && r_i == '0 && r_j == '0)
        else $error("compute transfer did not start the product sequence");

    a_prod_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prod_vld |-> $past(r_rd_vld))
        else $error("product stage valid without a preceding read");

endmodule

`default_nettype wire
